>>> hw/rtl/mma_pkg.sv
// ----------------------------------------------------------------------------
// MIDI message assembler package
// Shared item and message types, status byte constants and the data length
// lookup used by the classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mma_pkg;

    // Status byte boundaries.
    localparam logic [7:0] C_STATUS_FLAG  = 8'h80;
    localparam logic [7:0] C_SYSTEM_MIN   = 8'hF0;
    localparam logic [7:0] C_REALTIME_MIN = 8'hF8;

    // Default depth of the queue between classifier and parser.
    localparam int unsigned QUEUE_DEPTH = 2;

    // What the classifier found a received byte to be.
    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_CHANNEL,
        KIND_SYSTEM,
        KIND_REALTIME
    } t_kind;

    // One classified byte as it travels through the queue.
    typedef struct packed {
        t_kind       kind;
        logic [1:0]  len;
        logic [7:0]  value;
    } t_item;

    // One assembled message.
    typedef struct packed {
        logic [1:0]  data_count;
        logic [6:0]  second_data;
        logic [6:0]  first_data;
        logic [7:0]  msg_status;
    } t_msg;

    // Number of data bytes that follow a status byte.
    function automatic logic [1:0] data_len_of(input logic [7:0] status);
        logic [1:0] len;
        begin
            case (status[7:4]) inside
                4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 2'd2;
                4'hC, 4'hD:                   len = 2'd1;
                default:                      len = 2'd0;
            endcase
            return len;
        end
    endfunction

endpackage

>>> hw/rtl/mma_front.sv
// ----------------------------------------------------------------------------
// MIDI message assembler front end
// Accepts received bytes, sorts them into data, channel status, system and
// real-time bytes, and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mma_front (
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [7:0]    i_s_tdata,
    input  logic          i_queue_full,
    output logic          o_push,
    output mma_pkg::t_item o_item
);
    import mma_pkg::*;

    t_kind kind;

    always_comb begin
        if (i_s_tdata >= C_REALTIME_MIN) begin
            kind = KIND_REALTIME;
        end else if (i_s_tdata >= C_SYSTEM_MIN) begin
            kind = KIND_SYSTEM;
        end else if ((i_s_tdata & C_STATUS_FLAG) != 8'h00) begin
            kind = KIND_CHANNEL;
        end else begin
            kind = KIND_DATA;
        end
    end

    assign o_s_tready   = !i_queue_full;
    assign o_push       = i_s_tvalid && !i_queue_full;
    assign o_item.kind  = kind;
    assign o_item.len   = data_len_of(i_s_tdata);
    assign o_item.value = i_s_tdata;

endmodule

>>> hw/rtl/mma_queue.sv
// ----------------------------------------------------------------------------
// MIDI message assembler item queue
// Short register queue that decouples the classifier from the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mma_queue #(
    parameter int unsigned DEPTH = mma_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mma_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output mma_pkg::t_item o_item
);
    import mma_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count,  n_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> hw/rtl/mma_back.sv
// ----------------------------------------------------------------------------
// MIDI message assembler back end
// Holds the running status parser state, turns classified bytes into
// messages and keeps the finished message in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mma_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  mma_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output mma_pkg::t_msg  o_msg
);
    import mma_pkg::*;

    logic [7:0] r_running_status, n_running_status;
    logic [1:0] r_expected_length, n_expected_length;
    logic       r_byte_position, n_byte_position;
    logic [6:0] r_held_first_data, n_held_first_data;
    logic       r_out_valid, n_out_valid;
    t_msg       r_msg, n_msg;
    logic       take;
    logic       emit;
    t_msg       msg;

    // The output register can load when it is empty or its beat leaves now.
    assign o_pop = i_item_valid && (!r_out_valid || i_m_tready);
    assign take  = o_pop;

    always_comb begin
        n_running_status  = r_running_status;
        n_expected_length = r_expected_length;
        n_byte_position   = r_byte_position;
        n_held_first_data = r_held_first_data;
        emit              = 1'b0;
        msg               = '{data_count: 2'd0, second_data: 7'd0,
                              first_data: 7'd0, msg_status: i_item.value};
        case (i_item.kind)
            KIND_REALTIME: begin
                emit = 1'b1;
            end
            KIND_SYSTEM: begin
                n_running_status  = 8'h00;
                n_expected_length = 2'd0;
                n_byte_position   = 1'b0;
                emit              = 1'b1;
            end
            KIND_CHANNEL: begin
                n_running_status  = i_item.value;
                n_expected_length = i_item.len;
                n_byte_position   = 1'b0;
            end
            default: begin
                msg.msg_status = r_running_status;
                if (r_running_status == 8'h00 || r_expected_length == 2'd0) begin
                    emit = 1'b0;
                end else if (r_expected_length == 2'd1) begin
                    n_byte_position = 1'b0;
                    msg.first_data  = i_item.value[6:0];
                    msg.data_count  = 2'd1;
                    emit            = 1'b1;
                end else if (!r_byte_position) begin
                    n_held_first_data = i_item.value[6:0];
                    n_byte_position   = 1'b1;
                end else begin
                    n_byte_position = 1'b0;
                    msg.first_data  = r_held_first_data;
                    msg.second_data = i_item.value[6:0];
                    msg.data_count  = 2'd2;
                    emit            = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_m_tready;
        n_msg       = r_msg;
        if (take && emit) begin
            n_out_valid = 1'b1;
            n_msg       = msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_status  <= 8'h00;
            r_expected_length <= 2'd0;
            r_byte_position   <= 1'b0;
            r_held_first_data <= 7'd0;
            r_out_valid       <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (take) begin
                r_running_status  <= n_running_status;
                r_expected_length <= n_expected_length;
                r_byte_position   <= n_byte_position;
                r_held_first_data <= n_held_first_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_msg <= n_msg;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_msg      = r_msg;

endmodule

>>> hw/rtl/midi_message_assembler_top.sv
// ----------------------------------------------------------------------------
// MIDI message assembler
// Path: a completing byte is written into the queue, then popped into the output
// register, from which its message appears on the master side.
// Throughput: one received byte per cycle while the queue is not full, set by
// the parser step that pops one queued byte each cycle unless the output stalls.
// Reset: synchronous, active low; clears the running status, the queue and
// the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The block has three parts. The front end classifies each received byte as
// data, channel status, system common/exclusive or real-time and pushes it
// into a short queue. The back end pops one classified byte per cycle while
// its output register is empty or draining, updates the running status state
// and loads completed messages into that output register. Since the queue and
// the output register sit between the two sides, a stalled master side does
// not stop bytes from being accepted until the queue fills.
//
// Real-time bytes leave the running status alone, so they can be emitted in
// the middle of a channel message. System common and exclusive bytes are
// emitted as messages with no data and clear the running status; data bytes
// that follow them are dropped until a new channel status arrives.
module midi_message_assembler_top #(
    parameter int unsigned QUEUE_DEPTH = mma_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata    // [7:0] msg_status, [14:8] first_data,
                                          // [21:15] second_data, [23:22] data_count
);
    import mma_pkg::*;

    logic  push;
    logic  queue_full;
    t_item front_item;
    logic  queue_valid;
    t_item queue_item;
    logic  pop;
    t_msg  msg;

    mma_front u_front (
        .i_s_tvalid   (i_s_axis_tvalid),
        .o_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_item       (front_item)
    );

    mma_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    mma_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (queue_valid),
        .i_item       (queue_item),
        .o_pop        (pop),
        .o_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .o_msg        (msg)
    );

    // The message struct is laid out so its packed form is the beat layout.
    assign o_m_axis_tdata = msg;

    // A message that carries data always has a channel status byte.
    a_data_has_channel_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && msg.data_count != 2'd0) |->
        (msg.msg_status[7] && msg.msg_status < C_SYSTEM_MIN))
        else $error("data message without channel status");

    // Unused data fields are zero and the count never exceeds two.
    a_unused_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
        (msg.data_count != 2'd3 &&
         (msg.data_count == 2'd2 || msg.second_data == 7'd0) &&
         (msg.data_count != 2'd0 || msg.first_data == 7'd0)))
        else $error("message data fields inconsistent with data count");

    // A message without data is always a system or real-time byte.
    a_empty_is_system: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && msg.data_count == 2'd0) |-> (msg.msg_status >= C_SYSTEM_MIN))
        else $error("empty message with non-system status");

    // Reset leaves no message pending on the master side.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule
